// ===== rtl/thl_pkg.sv =====
// Shared types and constants of the thermal head line sequencer.
package thl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [11:0] LINE_DOTS_RST  = 12'd1280;
  localparam logic [15:0] HEAT_TICKS_RST = 16'd300;
  localparam logic [7:0]  WAIT_TICKS_RST = 8'd1;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_BLANK    = 2'd1,
    ST_PRINTED  = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [11:0] line_dots;
    logic [15:0] heat_ticks;
    logic [7:0]  latch_low_ticks;
    logic [7:0]  data_in_ticks;
    logic [7:0]  latch_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       latch_level;
    logic       strobe_on;
    logic       shift_valid;
    logic [7:0] shift_byte;
    logic       busy_res;
    logic [1:0] status;
  } res_t;

endpackage

// ===== rtl/thl_cfg_regs.sv =====
// Configuration register file of the thermal head line sequencer.
module thl_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [thl_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [thl_pkg::CFG_DATA_W-1:0]    wr_data,
  output thl_pkg::cfg_t                     cfg
);

  localparam logic [thl_pkg::CFG_IDX_W-1:0] IDX_LINE_DOTS  = 3'd0;
  localparam logic [thl_pkg::CFG_IDX_W-1:0] IDX_HEAT       = 3'd1;
  localparam logic [thl_pkg::CFG_IDX_W-1:0] IDX_LATCH_LOW  = 3'd2;
  localparam logic [thl_pkg::CFG_IDX_W-1:0] IDX_DATA_IN    = 3'd3;
  localparam logic [thl_pkg::CFG_IDX_W-1:0] IDX_LATCH_HIGH = 3'd4;

  thl_pkg::cfg_t cfg_r;
  thl_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        IDX_LINE_DOTS:  cfg_nxt.line_dots        = wr_data[11:0];
        IDX_HEAT:       cfg_nxt.heat_ticks       = wr_data;
        IDX_LATCH_LOW:  cfg_nxt.latch_low_ticks  = wr_data[7:0];
        IDX_DATA_IN:    cfg_nxt.data_in_ticks    = wr_data[7:0];
        IDX_LATCH_HIGH: cfg_nxt.latch_high_ticks = wr_data[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_dots        <= thl_pkg::LINE_DOTS_RST;
      cfg_r.heat_ticks       <= thl_pkg::HEAT_TICKS_RST;
      cfg_r.latch_low_ticks  <= thl_pkg::WAIT_TICKS_RST;
      cfg_r.data_in_ticks    <= thl_pkg::WAIT_TICKS_RST;
      cfg_r.latch_high_ticks <= thl_pkg::WAIT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/thl_line_mem.sv =====
// Line byte store: one write port, one read port with registered data.
module thl_line_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/thl_seq.sv =====
// Line collection and print phase sequencer around the line store.
module thl_seq #(
  parameter int MAX_LINE_BYTES = 256,
  parameter int AW             = 8,
  parameter int CW             = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  thl_pkg::cfg_t  cfg,
  input  logic           exec,
  input  thl_pkg::item_t item,
  input  logic [7:0]     rd_data,
  output logic [AW-1:0]  rd_addr,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [7:0]     wr_data,
  output thl_pkg::res_t  res
);

  localparam int LW = (CW > 9) ? CW : 9;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_LATCH_LOW  = 6'b000010,
    PH_SHIFT      = 6'b000100,
    PH_DATA_IN    = 6'b001000,
    PH_LATCH_HIGH = 6'b010000,
    PH_HEAT       = 6'b100000
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [15:0]   timer_r, timer_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic [CW-1:0] br_r, br_nxt;
  logic          ink_r, ink_nxt;

  logic [LW-1:0] dots_bytes;
  logic [CW-1:0] lb, ds, off, e, e_inc, e_rel;
  logic          pad, e_lt_lb, more;
  logic [15:0]   t_dec;
  logic          t_done;
  logic          room;

  assign dots_bytes = LW'(cfg.line_dots[11:3]);
  assign lb      = (dots_bytes > LW'(MAX_LINE_BYTES)) ? CW'(MAX_LINE_BYTES) : CW'(dots_bytes);
  assign ds      = (br_r < lb) ? br_r : lb;
  assign off     = lb - ds;
  assign e       = (phase_r == PH_LATCH_LOW) ? '0 : emit_r;
  assign e_inc   = e + CW'(1);
  assign e_rel   = e - off;
  assign pad     = (e < off);
  assign e_lt_lb = (e < lb);
  assign more    = (e_inc < lb);
  assign t_dec   = (timer_r == 16'd0) ? 16'd0 : timer_r - 16'd1;
  assign t_done  = (t_dec == 16'd0);
  assign room    = (br_r < CW'(MAX_LINE_BYTES));

  assign rd_addr = e_rel[AW-1:0];
  assign wr_addr = br_r[AW-1:0];
  assign wr_data = item.data_byte;

  thl_pkg::status_t st;
  logic             sv;
  logic [7:0]       sb;
  logic             run_shift, step_din, step_lh, step_heat;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    emit_nxt  = emit_r;
    br_nxt    = br_r;
    ink_nxt   = ink_r;
    st        = thl_pkg::ST_NONE;
    sv        = 1'b0;
    sb        = 8'h00;
    wr_en     = 1'b0;
    run_shift = 1'b0;
    step_din  = 1'b0;
    step_lh   = 1'b0;
    step_heat = 1'b0;
    if (exec) begin
      if (!item.command) begin
        if (phase_r != PH_IDLE) begin
          st = thl_pkg::ST_REJECTED;
        end else begin
          if (room) begin
            wr_en  = 1'b1;
            br_nxt = br_r + CW'(1);
          end
          ink_nxt = ink_r | (item.data_byte != 8'h00);
          if (item.last_byte) begin
            if (!ink_nxt) begin
              br_nxt  = '0;
              ink_nxt = 1'b0;
              st      = thl_pkg::ST_BLANK;
            end else begin
              phase_nxt = PH_LATCH_LOW;
              timer_nxt = 16'(cfg.latch_low_ticks);
            end
          end
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_LATCH_LOW: begin
            timer_nxt = t_dec;
            if (t_done) begin
              run_shift = 1'b1;
              emit_nxt  = '0;
            end
          end
          PH_SHIFT: run_shift = 1'b1;
          PH_DATA_IN: begin
            timer_nxt = t_dec;
            step_din  = t_done;
          end
          PH_LATCH_HIGH: begin
            timer_nxt = t_dec;
            step_lh   = t_done;
          end
          PH_HEAT: begin
            timer_nxt = t_dec;
            step_heat = t_done;
          end
          default: phase_nxt = PH_IDLE;
        endcase
        if (run_shift) begin
          if (e_lt_lb) begin
            sv       = 1'b1;
            sb       = pad ? 8'h00 : rd_data;
            emit_nxt = e_inc;
          end
          if (e_lt_lb && more) begin
            phase_nxt = PH_SHIFT;
          end else begin
            timer_nxt = 16'(cfg.data_in_ticks);
            if (cfg.data_in_ticks != 8'd0) phase_nxt = PH_DATA_IN;
            else step_din = 1'b1;
          end
        end
        if (step_din) begin
          timer_nxt = 16'(cfg.latch_high_ticks);
          if (cfg.latch_high_ticks != 8'd0) phase_nxt = PH_LATCH_HIGH;
          else step_lh = 1'b1;
        end
        if (step_lh) begin
          timer_nxt = cfg.heat_ticks;
          if (cfg.heat_ticks != 16'd0) phase_nxt = PH_HEAT;
          else step_heat = 1'b1;
        end
        if (step_heat) begin
          phase_nxt = PH_IDLE;
          timer_nxt = 16'd0;
          emit_nxt  = '0;
          br_nxt    = '0;
          ink_nxt   = 1'b0;
          st        = thl_pkg::ST_PRINTED;
        end
      end
    end
  end

  always_comb begin
    res.latch_level = !((phase_nxt == PH_LATCH_LOW) || (phase_nxt == PH_SHIFT) ||
                         (phase_nxt == PH_DATA_IN));
    res.strobe_on   = (phase_nxt == PH_HEAT);
    res.shift_valid = sv;
    res.shift_byte  = sb;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.status      = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= 16'd0;
      emit_r  <= '0;
      br_r    <= '0;
      ink_r   <= 1'b0;
    end else if (exec) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      emit_r  <= emit_nxt;
      br_r    <= br_nxt;
      ink_r   <= ink_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (phase_r == PH_IDLE))
    else $error("line store written during print sequence");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    br_r <= CW'(MAX_LINE_BYTES))
    else $error("received byte count beyond line store depth");

  a_shift_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && res.shift_valid) |-> ((phase_r == PH_SHIFT) || (phase_r == PH_LATCH_LOW)))
    else $error("byte shifted outside shift phase");

  a_printed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (res.status == thl_pkg::ST_PRINTED)) |=> ((phase_r == PH_IDLE) && (br_r == '0)))
    else $error("line state not cleared after print");
`endif

endmodule

// ===== rtl/thermal_head_line_sequencer.sv =====
// Top level of the thermal head line sequencer: handshakes, item and result registers.
//
//  channel  direction  payload
//  in_      slave      tdata[7:0] data_byte, tuser command, tlast last_byte
//  out_     master     tdata latch/strobe/shift_valid/shift_byte/busy/status
//  cfg_     slave      cfg_index register number, cfg_data write value
//
// Each transaction has an accept step that reads the line store and an update
// step that updates the sequencer state and loads the result register.
// A result waiting in the output register does not block the next input
// transaction; the update cycle waits until the output register is free.
// Reset clears control state and reloads the configuration defaults; the line store is not cleared.
// cfg_ready is always high.
module thermal_head_line_sequencer #(
  parameter int MAX_LINE_BYTES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tuser,   // [0] command
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] latch_level, [1] strobe_on, [2] shift_valid, [10:3] shift_byte,
  // [11] busy_res, [13:12] status, [15:14] zero
  output logic [15:0]                    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [thl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [thl_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int CW = $clog2(MAX_LINE_BYTES + 1);

  typedef enum logic [1:0] {
    CTL_ACCEPT = 2'b01,
    CTL_EXEC   = 2'b10
  } ctl_t;

  ctl_t           ctl_r, ctl_nxt;
  thl_pkg::item_t item_r;
  thl_pkg::res_t  res, res_r;
  logic           out_valid_r, out_valid_nxt;
  logic           in_fire, out_fire, exec;
  thl_pkg::cfg_t  cfg;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [7:0]     rd_data, wr_data;
  logic           wr_en;

  assign cfg_ready = 1'b1;
  assign in_tready = (ctl_r == CTL_ACCEPT);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign exec      = (ctl_r == CTL_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    ctl_nxt = ctl_r;
    unique case (ctl_r)
      CTL_ACCEPT: if (in_fire) ctl_nxt = CTL_EXEC;
      CTL_EXEC:   if (exec) ctl_nxt = CTL_ACCEPT;
      default:    ctl_nxt = CTL_ACCEPT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_fire) out_valid_nxt = 1'b0;
    if (exec) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= CTL_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.command   <= in_tuser;
      item_r.data_byte <= in_tdata;
      item_r.last_byte <= in_tlast;
    end
    if (exec) begin
      res_r <= res;
    end
  end

  thl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  thl_line_mem #(
    .DEPTH (MAX_LINE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  thl_seq #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .AW             (AW),
    .CW             (CW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .exec    (exec),
    .item    (item_r),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.status, res_r.busy_res, res_r.shift_byte,
                       res_r.shift_valid, res_r.strobe_on, res_r.latch_level};

`ifndef ASSERT_OFF
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while previous transaction in flight");
`endif

endmodule
